/* hw/rtl/vgcd_pkg.sv */
// Shared types and constants for the voxel grid centroid downsampler.
package vgcd_pkg;

  localparam int unsigned MAX_VOXELS_DEF  = 64;
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam logic [31:0] INV_SCALE_RESET = 32'd6553600;
  localparam int signed   IDX_MIN         = -32768;
  localparam int signed   IDX_MAX         = 32767;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last_point;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] centroid_x;
    logic signed [31:0] centroid_y;
    logic signed [31:0] centroid_z;
    logic [7:0]         mean_red;
    logic [7:0]         mean_green;
    logic [7:0]         mean_blue;
    logic [15:0]        point_count;
    logic               last_voxel;
    logic               points_dropped;
  } out_beat_t;

  // Division request and response between the emit walk and the divider.
  typedef struct packed {
    logic              start;
    logic signed [63:0] dividend;
    logic [31:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quotient;
  } div_rsp_t;

endpackage

/* hw/rtl/vgcd_quant.sv */
// Voxel index of one axis: floor(pos * scale / 2^32), clamped to 16 bits.
module vgcd_quant import vgcd_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] pos,
  input  logic [31:0]        scale,
  output logic signed [15:0] idx
);

  logic signed [64:0] prod_r;
  logic signed [32:0] q;

  // Register the product; the arithmetic shift gives the floor.
  always_ff @(posedge clk) begin
    prod_r <= 65'(pos) * $signed({1'b0, scale});
  end

  assign q = prod_r[64:32];

  // Clamp to the signed 16-bit range.
  always_comb begin
    if (q < 33'(IDX_MIN))      idx = 16'sh8000;
    else if (q > 33'(IDX_MAX)) idx = 16'sh7fff;
    else                       idx = q[15:0];
  end

endmodule

/* hw/rtl/vgcd_div.sv */
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module vgcd_div import vgcd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] dvs_r;
  logic        neg_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [63:0] mag;

  assign mag   = req.dividend[63] ? 64'(-req.dividend) : req.dividend;
  assign trial = {rem_r, quo_r[63]} - {33'd0, dvs_r};

  // Shift-subtract step.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      rem_nxt  = 64'd0;
      quo_nxt  = mag;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (!busy_r && req.start) begin
      dvs_r <= req.divisor;
      neg_r <= req.dividend[63];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

/* hw/rtl/voxel_grid_centroid_downsample_core.sv */
// Top level of the voxel grid centroid downsampler.
// Usage: pulse start with in_beat while busy is low to hand over one point.
// Configuration: cfg_we writes cfg_wdata into the inverse voxel scale; write
// it only while busy is low. A point passes through the index multiply, then
// the key search, which reads the held voxels of the key memory in order until
// a match or the last one, then the read-modify-write of the entry memory.
// Busy stays high meanwhile, so a new point is accepted only once the previous
// one is through.
// After a point with last_point set, the table is walked in order of first
// appearance. Each voxel needs six divisions, one after another in the
// shared divider, before its result leaves. Each result is on out_beat for
// one cycle with out_valid; the receiver cannot stall it.
// Then the table is empty again and busy falls.
// Reset (synchronous, rst_n low) empties the table, clears the drop flag
// and loads the scale with 100.0 in Q16.16. The memories need no clearing:
// only entries below the fill count are read.
module voxel_grid_centroid_downsample_core import vgcd_pkg::*; #(
  parameter int unsigned MAX_VOXELS  = MAX_VOXELS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_beat_t    in_beat,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output out_beat_t   out_beat
);

  localparam int unsigned AW = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
  localparam int unsigned UW = $clog2(MAX_VOXELS + 1);
  localparam int unsigned SW = 32 + COUNT_WIDTH;
  localparam int unsigned CW = 8 + COUNT_WIDTH;
  localparam int unsigned EW = COUNT_WIDTH + 3 * SW + 3 * CW;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MUL    = 9'b000000010,
    ST_SEARCH = 9'b000000100,
    ST_ERD    = 9'b000001000,
    ST_UPD    = 9'b000010000,
    ST_EMRD   = 9'b000100000,
    ST_DIV    = 9'b001000000,
    ST_DWAIT  = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0]     cnt;
    logic signed [SW-1:0]       sx;
    logic signed [SW-1:0]       sy;
    logic signed [SW-1:0]       sz;
    logic [CW-1:0]              sr;
    logic [CW-1:0]              sg;
    logic [CW-1:0]              sb;
  } entry_t;

  state_t state_r, state_nxt;
  logic [31:0] scale_r;
  in_beat_t    pt_r;
  logic [1:0]  mcnt_r;
  logic [UW-1:0] used_r;
  logic        drop_r;
  logic [AW-1:0] ptr_r;
  logic        hit_r;
  logic [AW-1:0] slot_r;
  logic        isnew_r;
  logic [2:0]  dsel_r;
  logic [63:0] quo_r [6];

  // Key and entry memories.
  logic [47:0] key_mem [MAX_VOXELS];
  logic [47:0] key_rd_r;
  logic [EW-1:0] ent_mem [MAX_VOXELS];
  logic [EW-1:0] ent_rd_r;
  entry_t ent_rd, ent_wr;

  logic signed [15:0] kx, ky, kz;
  logic [47:0] key;
  logic [AW-1:0] key_ra;
  logic          key_we;
  logic          ent_we;
  div_req_t dreq;
  div_rsp_t drsp;

  vgcd_quant u_qx (.clk(clk), .pos(pt_r.pos_x), .scale(scale_r), .idx(kx));
  vgcd_quant u_qy (.clk(clk), .pos(pt_r.pos_y), .scale(scale_r), .idx(ky));
  vgcd_quant u_qz (.clk(clk), .pos(pt_r.pos_z), .scale(scale_r), .idx(kz));
  vgcd_div   u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign key    = {kx, ky, kz};
  assign ent_rd = entry_t'(ent_rd_r);
  assign busy   = (state_r != ST_IDLE);

  // Key search reads one entry a cycle; the address leads by one.
  always_comb begin
    key_ra = ptr_r;
    if (state_r == ST_SEARCH) key_ra = ptr_r + AW'(1);
    if (state_r == ST_MUL) key_ra = '0;
  end

  always_ff @(posedge clk) begin
    key_rd_r <= key_mem[key_ra];
    if (key_we) key_mem[slot_r] <= key;
  end

  always_ff @(posedge clk) begin
    ent_rd_r <= ent_mem[state_r == ST_ERD ? slot_r : ptr_r];
    if (ent_we) ent_mem[slot_r] <= EW'(ent_wr);
  end

  // Accumulate the point into the entry, starting from zero for a new key.
  always_comb begin
    entry_t b;
    b = isnew_r ? '0 : ent_rd;
    ent_wr     = b;
    ent_wr.cnt = b.cnt + COUNT_WIDTH'(1);
    ent_wr.sx  = b.sx + SW'(pt_r.pos_x);
    ent_wr.sy  = b.sy + SW'(pt_r.pos_y);
    ent_wr.sz  = b.sz + SW'(pt_r.pos_z);
    ent_wr.sr  = b.sr + CW'(pt_r.red);
    ent_wr.sg  = b.sg + CW'(pt_r.green);
    ent_wr.sb  = b.sb + CW'(pt_r.blue);
  end

  logic accept_ok;
  assign accept_ok = (isnew_r || ent_rd.cnt != CNT_MAX) && (hit_r || !isnew_r ||
                     used_r != UW'(MAX_VOXELS));
  assign ent_we = (state_r == ST_UPD) && accept_ok;
  assign key_we = ent_we && isnew_r;

  // Divider operand selection for the emit walk.
  always_comb begin
    dreq.start   = (state_r == ST_DIV);
    dreq.divisor = 32'(ent_rd.cnt);
    case (dsel_r)
      3'd0:    dreq.dividend = 64'(ent_rd.sx);
      3'd1:    dreq.dividend = 64'(ent_rd.sy);
      3'd2:    dreq.dividend = 64'(ent_rd.sz);
      3'd3:    dreq.dividend = 64'($unsigned(ent_rd.sr));
      3'd4:    dreq.dividend = 64'($unsigned(ent_rd.sg));
      default: dreq.dividend = 64'($unsigned(ent_rd.sb));
    endcase
  end

  logic last_ent;
  assign last_ent = (UW'(ptr_r) + UW'(1) == used_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_MUL;
      ST_MUL:    if (mcnt_r == 2'd1) state_nxt = (used_r == '0) ? ST_ERD : ST_SEARCH;
      ST_SEARCH: if (key_rd_r == key || last_ent) state_nxt = ST_ERD;
      ST_ERD:    state_nxt = ST_UPD;
      ST_UPD:    state_nxt = pt_r.last_point ? ST_EMRD : ST_IDLE;
      ST_EMRD:   state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_DWAIT;
      ST_DWAIT:  if (drsp.done) state_nxt = (dsel_r == 3'd5) ? ST_OUT : ST_DIV;
      ST_OUT:    state_nxt = last_ent ? ST_IDLE : ST_EMRD;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scale_r <= INV_SCALE_RESET;
      used_r  <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) scale_r <= cfg_wdata;
      if (state_r == ST_UPD) begin
        if (!accept_ok) drop_r <= 1'b1;
        else if (isnew_r) used_r <= used_r + UW'(1);
      end
      if (state_r == ST_OUT && last_ent) begin
        used_r <= '0;
        drop_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        pt_r   <= in_beat;
        mcnt_r <= 2'd2;
        ptr_r  <= '0;
      end
      ST_MUL: begin
        mcnt_r  <= mcnt_r - 2'd1;
        hit_r   <= 1'b0;
        isnew_r <= 1'b1;
        slot_r  <= AW'(used_r);
      end
      ST_SEARCH: begin
        if (key_rd_r == key) begin
          hit_r   <= 1'b1;
          isnew_r <= 1'b0;
          slot_r  <= ptr_r;
        end
        ptr_r <= ptr_r + AW'(1);
      end
      ST_UPD: begin
        ptr_r  <= '0;
        dsel_r <= 3'd0;
      end
      ST_DWAIT: if (drsp.done) begin
        quo_r[dsel_r] <= drsp.quotient;
        dsel_r <= dsel_r + 3'd1;
      end
      ST_OUT: begin
        ptr_r  <= ptr_r + AW'(1);
        dsel_r <= 3'd0;
      end
      default: ;
    endcase
  end

  // Result beat.
  always_comb begin
    out_valid                = (state_r == ST_OUT);
    out_beat.centroid_x      = quo_r[0][31:0];
    out_beat.centroid_y      = quo_r[1][31:0];
    out_beat.centroid_z      = quo_r[2][31:0];
    out_beat.mean_red        = quo_r[3][7:0];
    out_beat.mean_green      = quo_r[4][7:0];
    out_beat.mean_blue       = quo_r[5][7:0];
    out_beat.point_count     = 16'(ent_rd.cnt);
    out_beat.last_voxel      = last_ent;
    out_beat.points_dropped  = drop_r;
  end

endmodule
